FILE: hw/rtl/assert_macros.svh
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define GDD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property whose consequent is checked in the cycle after its antecedent
`define GDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/gdd_pkg.sv
// types, constants and calendar tables for the gregorian date difference core
// no dependencies
package gdd_pkg;

   localparam int unsigned DayWidth   = 5;
   localparam int unsigned MonthWidth = 4;
   localparam int unsigned YearWidth  = 14;
   localparam int unsigned NumWidth   = 23;
   localparam int unsigned DiffWidth  = 24;

   // floor(y / 100) as (y * Recip100) >> Recip100Shift, exact for y below 43690
   localparam logic [15:0] Recip100      = 16'd41944;
   localparam int unsigned Recip100Shift = 22;

   localparam logic [MonthWidth-1:0] MonthFeb = 4'd2;

   typedef struct packed {
      logic [DayWidth-1:0]   day;
      logic [MonthWidth-1:0] month;
      logic [YearWidth-1:0]  year;
   } date_type;

   typedef struct packed {
      logic                ok;
      logic [NumWidth-1:0] num;
   } date_result_type;

   typedef struct packed {
      logic [DayWidth-1:0]   first_day;
      logic [MonthWidth-1:0] first_month;
      logic [YearWidth-1:0]  first_year;
      logic [DayWidth-1:0]   second_day;
      logic [MonthWidth-1:0] second_month;
      logic [YearWidth-1:0]  second_year;
   } req_word_type;

   typedef struct packed {
      logic signed [DiffWidth-1:0] day_difference;
      logic                        dates_valid;
   } rsp_word_type;

   // length of a common-year month, zero for a code that is no month
   function automatic logic [DayWidth-1:0] month_len(input logic [MonthWidth-1:0] m);
      logic [DayWidth-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days in a common year ahead of the first of the month
   function automatic logic [8:0] days_before_month(input logic [MonthWidth-1:0] m);
      logic [8:0] n;
      unique case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

FILE: hw/rtl/gdd_day_number.sv
// three-stage day number unit: checks one date and counts days from 1 jan of year 0
// depends on gdd_pkg
module gdd_day_number (
   input  logic                     clock,
   input  logic                     enable,
   input  gdd_pkg::date_type        date_in,
   output gdd_pkg::date_result_type result
);

   // stage 1: century quotient by reciprocal multiply
   gdd_pkg::date_type s1_date_ff;
   logic [7:0]        s1_q100_ff;
   logic [29:0]       q100_prod;
   logic [7:0]        q100_in;

   assign q100_prod = {16'd0, date_in.year} * {14'd0, gdd_pkg::Recip100};
   assign q100_in   = q100_prod[gdd_pkg::Recip100Shift +: 8];

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_date_ff <= date_in;
         s1_q100_ff <= q100_in;
      end
   end

   // stage 2: leap rule, leap day count and date check
   gdd_pkg::date_type s2_date_ff;
   logic              s2_leap_ff;
   logic [12:0]       s2_leaps_ff;
   logic              s2_ok_ff;
   logic [14:0]       hundreds;
   logic [6:0]        r100;
   logic              r100_nz;
   logic              leap_in;
   logic [12:0]       ceil4;
   logic [12:0]       ceil100;
   logic [12:0]       ceil400;
   logic [12:0]       leaps_in;
   logic [4:0]        len;
   logic              ok_in;

   always_comb begin
      hundreds = {7'd0, s1_q100_ff} * 15'd100;
      r100     = 7'({1'b0, s1_date_ff.year} - hundreds);
      r100_nz  = (r100 != 7'd0);
      leap_in  = ((s1_date_ff.year[1:0] == 2'd0) && r100_nz) ||
                 (!r100_nz && (s1_q100_ff[1:0] == 2'd0));
      ceil4    = 13'(({1'b0, s1_date_ff.year} + 15'd3) >> 2);
      ceil100  = {5'd0, s1_q100_ff} + {12'd0, r100_nz};
      ceil400  = {7'd0, s1_q100_ff[7:2]} +
                 {12'd0, (r100_nz || (s1_q100_ff[1:0] != 2'd0))};
      leaps_in = ceil4 - ceil100 + ceil400;
      len      = gdd_pkg::month_len(s1_date_ff.month);
      if ((s1_date_ff.month == gdd_pkg::MonthFeb) && leap_in) begin
         len = 5'd29;
      end
      ok_in    = (s1_date_ff.day != 5'd0) && (s1_date_ff.day <= len);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_date_ff  <= s1_date_ff;
         s2_leap_ff  <= leap_in;
         s2_leaps_ff <= leaps_in;
         s2_ok_ff    <= ok_in;
      end
   end

   // stage 3: day number
   gdd_pkg::date_result_type s3_result_ff;
   gdd_pkg::date_result_type s3_result_in;
   logic [22:0]              year_days;
   logic                     after_feb;

   always_comb begin
      year_days  = {9'd0, s2_date_ff.year} * 23'd365;
      after_feb  = (s2_date_ff.month > gdd_pkg::MonthFeb) && s2_leap_ff;
      s3_result_in.ok  = s2_ok_ff;
      s3_result_in.num = year_days + {10'd0, s2_leaps_ff} +
                         {14'd0, gdd_pkg::days_before_month(s2_date_ff.month)} +
                         {22'd0, after_feb} + {18'd0, s2_date_ff.day} - 23'd1;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s3_result_ff <= s3_result_in;
      end
   end

   assign result = s3_result_ff;

endmodule

FILE: hw/rtl/gregorian_date_difference_core.sv
// top level of the gregorian date difference core: two day number units and the subtract
// depends on gdd_pkg, gdd_day_number and assert_macros.svh
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  two dates (day, month, year each)
//   rsp      out        rsp_valid/rsp_stall  signed day difference and valid flag
//
// rsp_valid rises as a word enters the output register; one per cycle unless stalled.
// three stages sit in each day number unit (quotient, leap count, day number),
// the fourth is the subtract into the output register.
// reset clears the stage valid bits and rsp_valid only; payload registers are not reset.
// a stalled rsp word freezes the whole pipeline and raises req_stall.
`include "assert_macros.svh"

module gregorian_date_difference_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gdd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gdd_pkg::rsp_word_type rsp_word
);

   // pipeline advance
   logic enable;
   logic rsp_valid_ff;

   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;

   // per-stage valid bits
   logic [2:0] stage_valid_ff;
   logic [2:0] stage_valid_in;

   assign stage_valid_in = {stage_valid_ff[1:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 3'd0;
         rsp_valid_ff   <= 1'b0;
      end else if (enable) begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= stage_valid_ff[2];
      end
   end

   // day numbers of both dates
   gdd_pkg::date_type        first_date;
   gdd_pkg::date_type        second_date;
   gdd_pkg::date_result_type first_num;
   gdd_pkg::date_result_type second_num;

   assign first_date.day    = req_word.first_day;
   assign first_date.month  = req_word.first_month;
   assign first_date.year   = req_word.first_year;
   assign second_date.day   = req_word.second_day;
   assign second_date.month = req_word.second_month;
   assign second_date.year  = req_word.second_year;

   gdd_day_number first_unit (
      .clock   (clock),
      .enable  (enable),
      .date_in (first_date),
      .result  (first_num)
   );

   gdd_day_number second_unit (
      .clock   (clock),
      .enable  (enable),
      .date_in (second_date),
      .result  (second_num)
   );

   // difference into the output register
   gdd_pkg::rsp_word_type rsp_word_ff;
   gdd_pkg::rsp_word_type rsp_word_in;

   always_comb begin
      rsp_word_in.dates_valid = first_num.ok && second_num.ok;
      if (rsp_word_in.dates_valid) begin
         rsp_word_in.day_difference = $signed({1'b0, second_num.num} - {1'b0, first_num.num});
      end else begin
         rsp_word_in.day_difference = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // checks
   `GDD_ASSERT(a_invalid_zero, clock, reset,
      !rsp_valid_ff || rsp_word_ff.dates_valid || (rsp_word_ff.day_difference == 24'sd0),
      "invalid dates with nonzero difference")
   `GDD_ASSERT(a_diff_range, clock, reset,
      !rsp_valid_ff || ((rsp_word_ff.day_difference <= 24'sd5984132) &&
      (rsp_word_ff.day_difference >= -24'sd5984132)),
      "difference out of range")
   `GDD_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall,
      stage_valid_ff[0], "accepted word did not enter stage one")
   `GDD_ASSERT_NEXT(a_stall_holds, clock, reset, req_stall,
      $stable(stage_valid_ff) && rsp_valid_ff, "pipeline moved while stalled")

endmodule
